@@ hw/rtl/gicdf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gicdf_pkg
// Shared types and constants of the Gaussian inverse-CDF interpolator.
// ----------------------------------------------------------------------------
package gicdf_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned ZFIELD_W    = 10;
  localparam int unsigned LIN_W       = 4;
  localparam int unsigned X_W         = 17;
  localparam int unsigned SEG_W       = 6;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned SLOPE_W     = 24;
  localparam int unsigned OFFSET_W    = 32;
  localparam int unsigned PROD_W      = SLOPE_W + X_W;
  localparam int unsigned ENTRY_W     = SLOPE_W + OFFSET_W;
  localparam int unsigned TABLE_DEPTH = 1 << IDX_W;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned POS_W       = 5;

  // Leading-zero count of an all-zero exponent field, and the final segment.
  localparam logic [CNT_W-1:0] ZERO_RUN  = CNT_W'(10);
  localparam logic [SEG_W-1:0] LAST_SEG  = SEG_W'(60);
  localparam int unsigned      FRAC_BITS = 28;
  // Single-precision bias less the fixed-point scaling.
  localparam logic [7:0]       EXP_ADJ   = 8'(127 - FRAC_BITS);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    OP_CONVERT = 1'b0,
    OP_LOAD    = 1'b1
  } op_t;

  // One command from the front end to the back end.
  typedef struct packed {
    op_t                 op;
    logic                sign;
    logic [X_W-1:0]      x;
    logic [IDX_W-1:0]    idx;
    logic [SLOPE_W-1:0]  slope;
    logic [OFFSET_W-1:0] offset;
  } cmd_t;

endpackage : gicdf_pkg
`default_nettype wire

@@ hw/rtl/gicdf_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gicdf_front
// Accepts input items, counts leading zeros, keeps the segment accumulator
// and hands table loads and emitting conversions to the command queue.
// ----------------------------------------------------------------------------
module gicdf_front
  import gicdf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire op_t                 in_op,
  input  wire logic [WORD_W-1:0]   in_word,
  input  wire logic [IDX_W-1:0]    in_idx,
  input  wire logic [SLOPE_W-1:0]  in_slope,
  input  wire logic [OFFSET_W-1:0] in_offset,
  input  wire logic                q_full,
  output logic                     push,
  output cmd_t                     push_cmd
);

  logic [SEG_W-1:0]    seg_total;
  logic [SEG_W-1:0]    seg_total_next;
  logic [SEG_W-1:0]    seg_sum;
  logic [CNT_W-1:0]    lz_cnt;
  logic [ZFIELD_W-1:0] zfield;
  logic                accept;
  logic                emit;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign zfield   = in_word[WORD_W-2 -: ZFIELD_W];

  always_comb begin
    lz_cnt = ZERO_RUN;
    for (int i = 0; i < ZFIELD_W; i++) begin
      if (zfield[i]) begin
        lz_cnt = CNT_W'(ZFIELD_W - 1 - i);
      end
    end
  end

  assign seg_sum = seg_total + SEG_W'(lz_cnt);
  assign emit    = (lz_cnt != ZERO_RUN) || (seg_sum == LAST_SEG);

  always_comb begin
    seg_total_next = seg_total;
    if (accept && in_op == OP_CONVERT) begin
      seg_total_next = emit ? '0 : seg_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_total <= '0;
    end else begin
      seg_total <= seg_total_next;
    end
  end

  assign push = accept && (in_op == OP_LOAD || emit);

  always_comb begin
    push_cmd.op     = in_op;
    push_cmd.sign   = in_word[WORD_W-1];
    push_cmd.x      = in_word[X_W-1:0];
    push_cmd.slope  = in_slope;
    push_cmd.offset = in_offset;
    if (in_op == OP_LOAD) begin
      push_cmd.idx = in_idx;
    end else begin
      push_cmd.idx = {seg_sum, in_word[X_W +: LIN_W]};
    end
  end

  // The accumulator only ever holds whole runs of all-zero fields.
  a_seg_bound : assert property (@(posedge clk) disable iff (rst)
    seg_total <= LAST_SEG - SEG_W'(ZERO_RUN))
    else $error("segment accumulator out of range");

  a_emit_clears : assert property (@(posedge clk) disable iff (rst)
    (accept && in_op == OP_CONVERT && emit) |=> seg_total == '0)
    else $error("segment accumulator not cleared after emit");

endmodule : gicdf_front
`default_nettype wire

@@ hw/rtl/gicdf_cmd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gicdf_cmd_queue
// Short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module gicdf_cmd_queue
  import gicdf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  output logic      head_valid,
  output cmd_t      head_cmd,
  input  wire logic pop
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QDEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("command queue overflow");

endmodule : gicdf_cmd_queue
`default_nettype wire

@@ hw/rtl/gicdf_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gicdf_back
// Holds the coefficient table, interpolates slope*x + offset and converts the
// fixed-point value to a scaled single-precision pattern.
// ----------------------------------------------------------------------------
module gicdf_back
  import gicdf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire cmd_t              head_cmd,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WORD_W-1:0]      out_bits
);

  logic [ENTRY_W-1:0]  coef_mem [TABLE_DEPTH];
  logic                adv;

  logic                v1, v2, v3, v4;
  logic [ENTRY_W-1:0]  rd1;
  logic                sign1, sign2, sign3, sign4;
  logic [X_W-1:0]      x1;
  logic [SLOPE_W-1:0]  prod2;
  logic [OFFSET_W-1:0] offset2;
  logic [WORD_W-1:0]   fixed3, fixed4;
  logic [PROD_W-1:0]   prod_full;
  logic [POS_W-1:0]    msb3, msb4;
  logic                zero4;

  logic [WORD_W-1:0]   norm;
  logic [23:0]         mant;
  logic [24:0]         mant_rnd;
  logic                round_up;
  logic [7:0]          exp_field;
  logic [WORD_W-1:0]   result;

  // The whole pipeline moves when the output register can take a new value.
  assign adv = !out_valid || out_ready;
  assign pop = head_valid && adv;

  always_ff @(posedge clk) begin
    if (pop && head_cmd.op == OP_LOAD) begin
      coef_mem[head_cmd.idx] <= {head_cmd.slope, head_cmd.offset};
    end
    if (adv) begin
      rd1 <= coef_mem[head_cmd.idx];
    end
  end

  assign prod_full = rd1[ENTRY_W-1 -: SLOPE_W] * PROD_W'(x1);

  always_comb begin
    msb3 = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (fixed3[i]) begin
        msb3 = POS_W'(i);
      end
    end
  end

  always_comb begin
    norm      = fixed4 << (POS_W'(WORD_W - 1) - msb4);
    mant      = norm[WORD_W-1 -: 24];
    round_up  = norm[7] && ((|norm[6:0]) || mant[0]);
    mant_rnd  = {1'b0, mant} + 25'(round_up);
    exp_field = 8'(msb4) + EXP_ADJ + 8'(mant_rnd[24]);
    if (zero4) begin
      result = {sign4, 31'd0};
    end else if (mant_rnd[24]) begin
      result = {sign4, exp_field, 23'd0};
    end else begin
      result = {sign4, exp_field, mant_rnd[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sign1   <= head_cmd.sign;
      x1      <= head_cmd.x;
      prod2   <= prod_full[PROD_W-1 -: SLOPE_W];
      offset2 <= rd1[OFFSET_W-1:0];
      sign2   <= sign1;
      fixed3  <= WORD_W'(prod2) + offset2;
      sign3   <= sign2;
      fixed4  <= fixed3;
      msb4    <= msb3;
      zero4   <= fixed3 == '0;
      sign4   <= sign3;
      out_bits <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= pop && head_cmd.op == OP_CONVERT;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // A table load never turns into a result.
  a_load_no_result : assert property (@(posedge clk) disable iff (rst)
    (pop && head_cmd.op == OP_LOAD) |=> !v1)
    else $error("table load entered the datapath as a result");

  a_out_from_pipe : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v4))
    else $error("result appeared without a conversion in flight");

endmodule : gicdf_back
`default_nettype wire

@@ hw/rtl/gaussian_icdf_segmented_interpolator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_icdf_segmented_interpolator
// Gaussian sampler by piecewise-linear inverse CDF over hierarchical segments.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle and keeps that rate as long as the
// output side takes results. An item with tuser set writes one coefficient
// table entry; any other item converts a uniform word. A word whose exponent
// field is all zeros and that does not reach the final segment gives no
// result. After its word is accepted, a result passes through the command
// queue, the table read, the multiply, the offset add, the leading-one
// search and the rounding stage, each registered; the back end holds while
// the output stalls. The table has a single write and a single read port
// and takes one command per cycle in input order while the output is not
// stalled, so a load is visible to the conversion that follows it. Table
// entries hold nothing meaningful until loaded.
module gaussian_icdf_segmented_interpolator
  import gicdf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // uniform_word[31:0], entry_index[41:32], entry_slope[65:42],
  // entry_offset[97:66], zero pad[103:98]
  input  wire logic [103:0] s_axis_tdata,
  // action[0]
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // gaussian_bits[31:0]
  output logic [31:0]       m_axis_tdata
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  gicdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (op_t'(s_axis_tuser)),
    .in_word   (s_axis_tdata[31:0]),
    .in_idx    (s_axis_tdata[41:32]),
    .in_slope  (s_axis_tdata[65:42]),
    .in_offset (s_axis_tdata[97:66]),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  gicdf_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  gicdf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_bits   (m_axis_tdata)
  );

endmodule : gaussian_icdf_segmented_interpolator
`default_nettype wire
